[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the RTL of the heart rate block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/hrpb_pkg.sv]
// ----------------------------------------------------------------------------
// hrpb_pkg
// Types and constants shared by the heart rate peak and BPM estimator.
// ----------------------------------------------------------------------------
package hrpb_pkg;

    // Default depth of the beat interval window.
    localparam int WINDOW_DEF = 500;

    // Field widths.
    localparam int SAMPLE_W = 16;
    localparam int TIME_W   = 32;
    localparam int BPM_W    = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;

    // Register reset values.
    localparam logic [CFG_W-1:0] PEAK_MARGIN_RST  = 16'd1000;
    localparam logic [CFG_W-1:0] REARM_MARGIN_RST = 16'd500;

    // Beats per minute from an average interval in milliseconds.
    localparam logic [BPM_W-1:0] BPM_NUMERATOR = 16'd60000;
    localparam logic [BPM_W-1:0] BPM_ZERO_AVG  = 16'd60;

    // Shared divider: divisor width and the width of its step counter.
    localparam int DIV_DEN_W  = 32;
    localparam int DIV_STEP_W = 6;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PEAK_MARGIN  = 1'b0,
        CFG_REARM_MARGIN = 1'b1
    } cfg_index_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_UPDATE,
        S_DROP,
        S_DIV1,
        S_DIV1_WAIT,
        S_DIV2,
        S_DIV2_WAIT,
        S_OUT
    } state_t;

    // Command to the shared divider.
    typedef struct packed {
        logic                  start;
        logic [DIV_STEP_W-1:0] steps;
    } div_cmd_t;

endpackage

[rtl/hrpb_divider.sv]
// ----------------------------------------------------------------------------
// hrpb_divider
// Restoring divider, one quotient bit per cycle, shared by both divisions.
// ----------------------------------------------------------------------------
module hrpb_divider #(
    parameter int NUM_W = 41
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  hrpb_pkg::div_cmd_t               cmd,
    input  logic [NUM_W-1:0]                 dividend,
    input  logic [hrpb_pkg::DIV_DEN_W-1:0]   divisor,
    output logic [NUM_W-1:0]                 quotient,
    output logic                             done
);

    localparam int DEN_W = hrpb_pkg::DIV_DEN_W;

    logic                            busy_reg;
    logic                            done_reg;
    logic [hrpb_pkg::DIV_STEP_W-1:0] cnt_reg;
    logic [NUM_W-1:0]                quo_reg;
    logic [DEN_W-1:0]                rem_reg;
    logic [DEN_W-1:0]                den_reg;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           fits;

    // The dividend is shifted in from its top bit; after k steps the low k
    // bits of the shift register hold the quotient.
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= cmd.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == hrpb_pkg::DIV_STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

[rtl/hrpb_ring.sv]
// ----------------------------------------------------------------------------
// hrpb_ring
// Interval window storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module hrpb_ring #(
    parameter int DEPTH  = 500,
    parameter int ADDR_W = 9
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [ADDR_W-1:0]                 addr,
    input  logic [hrpb_pkg::TIME_W-1:0]       wdata,
    output logic [hrpb_pkg::TIME_W-1:0]       rdata
);

    logic [hrpb_pkg::TIME_W-1:0] mem [DEPTH];
    logic [hrpb_pkg::TIME_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/heart_rate_peak_bpm_unit.sv]
// ----------------------------------------------------------------------------
// heart_rate_peak_bpm_unit
// Peak detector with hysteresis and a BPM estimate over a window of beats.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake             Payload
//  item     in         item_valid/stall      sample, baseline, time_ms
//  result   out        result_valid/stall    peak_flag, beat_seen, rate_bpm
//  cfg      in         cfg_we (no wait)      cfg_index, cfg_data
//
//  An item without a beat passes S_EVAL and S_OUT on its way to the
//  result register. A beat also passes S_UPDATE, S_DROP and the runs of
//  the shared one-bit-per-cycle divider: SUM_W steps for the average
//  interval and 16 steps for the BPM value. A zero average skips the
//  second division. One item is in work at a time; item_stall is high
//  from acceptance until the result has been placed in the result
//  register. A result waiting under result_stall does not block the next
//  item, but the following result waits for the register to free up.
//  Reset (asynchronous, active low) clears all control state; the
//  interval memory is not cleared, since an entry is read only after it
//  was written.
//
`include "assert_macros.svh"

module heart_rate_peak_bpm_unit #(
    parameter int WINDOW = hrpb_pkg::WINDOW_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               item_valid,
    output logic                               item_stall,
    input  logic [hrpb_pkg::SAMPLE_W-1:0]      sample,
    input  logic [hrpb_pkg::SAMPLE_W-1:0]      baseline,
    input  logic [hrpb_pkg::TIME_W-1:0]        time_ms,

    output logic                               result_valid,
    input  logic                               result_stall,
    output logic                               peak_flag,
    output logic                               beat_seen,
    output logic [hrpb_pkg::BPM_W-1:0]         rate_bpm,

    input  logic                               cfg_we,
    input  logic [hrpb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hrpb_pkg::CFG_W-1:0]         cfg_data
);

    // Derived widths: ring address, fill count and the running sum, which
    // must hold WINDOW full-width intervals.
    localparam int HEAD_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = hrpb_pkg::TIME_W + CNT_W;
    localparam int CMP_W  = hrpb_pkg::SAMPLE_W + 1;
    localparam int BPM_PAD_W = SUM_W - hrpb_pkg::BPM_W;

    hrpb_pkg::state_t state_reg;
    hrpb_pkg::state_t state_next;

    // Configuration registers.
    logic [hrpb_pkg::CFG_W-1:0]    peak_margin_reg;
    logic [hrpb_pkg::CFG_W-1:0]    rearm_margin_reg;

    // Detector and window state.
    logic                          armed_reg;
    logic [hrpb_pkg::TIME_W-1:0]   last_peak_reg;
    logic [HEAD_W-1:0]             head_reg;
    logic [CNT_W-1:0]              count_reg;
    logic [SUM_W-1:0]              sum_reg;
    logic [hrpb_pkg::BPM_W-1:0]    bpm_reg;
    logic                          result_valid_reg;

    // Item being worked on and beat scratch values.
    logic [hrpb_pkg::SAMPLE_W-1:0] sample_reg;
    logic [hrpb_pkg::SAMPLE_W-1:0] baseline_reg;
    logic [hrpb_pkg::TIME_W-1:0]   time_reg;
    logic [hrpb_pkg::TIME_W-1:0]   gap_reg;
    logic [hrpb_pkg::TIME_W-1:0]   old_reg;
    logic                          drop_reg;
    logic                          beat_reg;

    // Result register payload.
    logic                          peak_flag_reg;
    logic                          beat_seen_reg;
    logic [hrpb_pkg::BPM_W-1:0]    rate_bpm_reg;

    // Sequencer outputs and datapath signals.
    hrpb_pkg::div_cmd_t            div_cmd;
    logic [SUM_W-1:0]              div_dividend;
    logic [hrpb_pkg::DIV_DEN_W-1:0] div_divisor;
    logic [SUM_W-1:0]              div_quotient;
    logic                          div_done;
    logic                          ring_we;
    logic [hrpb_pkg::TIME_W-1:0]   ring_rdata;
    logic                          item_accept;
    logic                          out_free;
    logic                          out_load;
    logic                          beat_now;
    logic                          rearm_now;
    logic                          window_full;
    logic                          avg_zero;
    logic [CMP_W-1:0]              peak_level;
    logic [CMP_W-1:0]              rearm_level;

    assign item_accept = item_valid && !item_stall;
    assign out_free    = !result_valid_reg || !result_stall;
    assign window_full = (count_reg == CNT_W'(WINDOW));
    assign avg_zero    = (div_quotient[hrpb_pkg::TIME_W-1:0] == '0);

    // Peak and rearm tests, at 17 bits so that the sums never wrap.
    assign peak_level  = {1'b0, baseline_reg} + {1'b0, peak_margin_reg};
    assign rearm_level = {1'b0, baseline_reg} + {1'b0, rearm_margin_reg};
    assign beat_now    = !armed_reg && ({1'b0, sample_reg} > peak_level);
    assign rearm_now   = ({1'b0, sample_reg} < rearm_level);

    // ------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hrpb_pkg::S_IDLE:
            begin
                if (item_accept)
                begin
                    state_next = hrpb_pkg::S_EVAL;
                end
            end
            hrpb_pkg::S_EVAL:
            begin
                state_next = beat_now ? hrpb_pkg::S_UPDATE : hrpb_pkg::S_OUT;
            end
            hrpb_pkg::S_UPDATE:
            begin
                state_next = hrpb_pkg::S_DROP;
            end
            hrpb_pkg::S_DROP:
            begin
                state_next = hrpb_pkg::S_DIV1;
            end
            hrpb_pkg::S_DIV1:
            begin
                state_next = hrpb_pkg::S_DIV1_WAIT;
            end
            hrpb_pkg::S_DIV1_WAIT:
            begin
                if (div_done)
                begin
                    state_next = avg_zero ? hrpb_pkg::S_OUT : hrpb_pkg::S_DIV2;
                end
            end
            hrpb_pkg::S_DIV2:
            begin
                state_next = hrpb_pkg::S_DIV2_WAIT;
            end
            hrpb_pkg::S_DIV2_WAIT:
            begin
                if (div_done)
                begin
                    state_next = hrpb_pkg::S_OUT;
                end
            end
            hrpb_pkg::S_OUT:
            begin
                if (out_free)
                begin
                    state_next = hrpb_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = hrpb_pkg::S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs.
    // ------------------------------------------------------------------
    always_comb
    begin
        item_stall    = 1'b1;
        ring_we       = 1'b0;
        out_load      = 1'b0;
        div_cmd.start = 1'b0;
        div_cmd.steps = hrpb_pkg::DIV_STEP_W'(SUM_W);
        div_dividend  = sum_reg;
        div_divisor   = hrpb_pkg::DIV_DEN_W'(count_reg);
        unique case (state_reg)
            hrpb_pkg::S_IDLE:
            begin
                item_stall = 1'b0;
            end
            hrpb_pkg::S_UPDATE:
            begin
                ring_we = 1'b1;
            end
            hrpb_pkg::S_DIV1:
            begin
                div_cmd.start = 1'b1;
            end
            hrpb_pkg::S_DIV2:
            begin
                // 60000 placed at the top of the dividend, 16 steps only.
                div_cmd.start = 1'b1;
                div_cmd.steps = hrpb_pkg::DIV_STEP_W'(hrpb_pkg::BPM_W);
                div_dividend  = {hrpb_pkg::BPM_NUMERATOR, {BPM_PAD_W{1'b0}}};
                div_divisor   = div_quotient[hrpb_pkg::DIV_DEN_W-1:0];
            end
            hrpb_pkg::S_OUT:
            begin
                out_load = out_free;
            end
            hrpb_pkg::S_EVAL, hrpb_pkg::S_DROP, hrpb_pkg::S_DIV1_WAIT,
            hrpb_pkg::S_DIV2_WAIT:
            begin
                item_stall = 1'b1;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= hrpb_pkg::S_IDLE;
            peak_margin_reg  <= hrpb_pkg::PEAK_MARGIN_RST;
            rearm_margin_reg <= hrpb_pkg::REARM_MARGIN_RST;
            armed_reg        <= 1'b0;
            last_peak_reg    <= '0;
            head_reg         <= '0;
            count_reg        <= '0;
            sum_reg          <= '0;
            bpm_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    hrpb_pkg::CFG_PEAK_MARGIN:  peak_margin_reg  <= cfg_data;
                    hrpb_pkg::CFG_REARM_MARGIN: rearm_margin_reg <= cfg_data;
                    default:                    peak_margin_reg  <= peak_margin_reg;
                endcase
            end

            // A beat arms the detector; a sample under the rearm level
            // disarms it, even on the item that started the beat.
            if (state_reg == hrpb_pkg::S_EVAL)
            begin
                armed_reg <= (armed_reg || beat_now) && !rearm_now;
            end

            // Window update: the new interval goes in at the head, the sum
            // takes it now and drops the replaced entry in S_DROP, the state after.
            if (state_reg == hrpb_pkg::S_UPDATE)
            begin
                last_peak_reg <= time_reg;
                sum_reg       <= sum_reg + SUM_W'(gap_reg);
                head_reg      <= (head_reg == HEAD_W'(WINDOW - 1)) ?
                                 '0 : head_reg + 1'b1;
                if (!window_full)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end

            if (state_reg == hrpb_pkg::S_DROP && drop_reg)
            begin
                sum_reg <= sum_reg - SUM_W'(old_reg);
            end

            if (state_reg == hrpb_pkg::S_DIV1_WAIT && div_done && avg_zero)
            begin
                bpm_reg <= hrpb_pkg::BPM_ZERO_AVG;
            end

            if (state_reg == hrpb_pkg::S_DIV2_WAIT && div_done)
            begin
                bpm_reg <= div_quotient[hrpb_pkg::BPM_W-1:0];
            end

            if (out_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            sample_reg   <= sample;
            baseline_reg <= baseline;
            time_reg     <= time_ms;
        end

        if (state_reg == hrpb_pkg::S_EVAL)
        begin
            beat_reg <= beat_now;
            gap_reg  <= time_reg - last_peak_reg;
        end

        // The ring read data holds the entry at the head, which is the
        // oldest interval once the window is full.
        if (state_reg == hrpb_pkg::S_UPDATE)
        begin
            old_reg  <= ring_rdata;
            drop_reg <= window_full;
        end

        if (out_load)
        begin
            peak_flag_reg <= armed_reg;
            beat_seen_reg <= beat_reg;
            rate_bpm_reg  <= bpm_reg;
        end
    end

    hrpb_ring #(
        .DEPTH  (WINDOW),
        .ADDR_W (HEAD_W)
    ) u_ring (
        .clk    (clk),
        .we     (ring_we),
        .addr   (head_reg),
        .wdata  (gap_reg),
        .rdata  (ring_rdata)
    );

    hrpb_divider #(
        .NUM_W  (SUM_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (div_cmd),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .done     (div_done)
    );

    assign result_valid = result_valid_reg;
    assign peak_flag    = peak_flag_reg;
    assign beat_seen    = beat_seen_reg;
    assign rate_bpm     = rate_bpm_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_W'(WINDOW))
    `ASSERT_ALWAYS(a_head_bound, clk, rst_n, head_reg <= HEAD_W'(WINDOW - 1))
    `ASSERT_IMPLIES(a_div_done_waited, clk, rst_n, div_done, (state_reg == hrpb_pkg::S_DIV1_WAIT) || (state_reg == hrpb_pkg::S_DIV2_WAIT))
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, item_accept, item_stall)

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: heart_rate_peak_bpm_unit regression
// Drives filtered samples with baselines and timestamps into the peak and BPM
// unit, predicts every reading from a behavioral copy of the detector and the
// beat interval window, and compares each reading field by field.
// ----------------------------------------------------------------------------

import hrpb_pkg::*;

// One reading as the unit reports it for a sample.
typedef struct packed {
    logic             peak_flag;
    logic             beat_seen;
    logic [BPM_W-1:0] rate_bpm;
} reading_t;

// Tracks the detector and the interval window, and holds the readings that
// accepted samples are due to produce.
class pulse_tracker;
    localparam int DEPTH = WINDOW_DEF;

    logic [CFG_W-1:0]  rise_margin;
    logic [CFG_W-1:0]  fall_margin;
    logic              in_peak;
    logic [TIME_W-1:0] prev_beat_ms;
    logic [TIME_W-1:0] gaps [DEPTH];
    int                slot;
    int                filled;
    logic [63:0]       gap_total;
    logic [BPM_W-1:0]  bpm_now;
    reading_t          due_readings [$];
    int                mismatches;

    function new();
        rise_margin  = PEAK_MARGIN_RST;
        fall_margin  = REARM_MARGIN_RST;
        in_peak      = 1'b0;
        prev_beat_ms = '0;
        slot         = 0;
        filled       = 0;
        gap_total    = '0;
        bpm_now      = '0;
        mismatches   = 0;
    endfunction

    function void set_margin(cfg_index_t idx, logic [CFG_W-1:0] value);
        case (idx)
            CFG_PEAK_MARGIN:  rise_margin = value;
            CFG_REARM_MARGIN: fall_margin = value;
            default:          ;
        endcase
    endfunction

    // Works out the reading of one accepted sample and queues it.
    function void take_sample(logic [SAMPLE_W-1:0] s, logic [SAMPLE_W-1:0] b,
                              logic [TIME_W-1:0] t);
        reading_t          r;
        logic [SAMPLE_W:0] rise_level;
        logic [SAMPLE_W:0] fall_level;
        logic [TIME_W-1:0] gap;
        logic [TIME_W-1:0] avg;
        // Levels are compared at 17 bits so that a high baseline never wraps.
        rise_level = {1'b0, b} + {1'b0, rise_margin};
        fall_level = {1'b0, b} + {1'b0, fall_margin};
        r.beat_seen = 1'b0;
        if (!in_peak && ({1'b0, s} > rise_level))
        begin
            in_peak = 1'b1;
            r.beat_seen = 1'b1;
            gap = t - prev_beat_ms;
            prev_beat_ms = t;
            // A full window drops its oldest interval at the slot being reused.
            if (filled == DEPTH)
                gap_total -= gaps[slot];
            else
                filled++;
            gaps[slot] = gap;
            gap_total += gap;
            slot = (slot + 1 == DEPTH) ? 0 : slot + 1;
            avg = TIME_W'(gap_total / 64'(filled));
            bpm_now = (avg != 0) ? BPM_W'(32'(BPM_NUMERATOR) / avg) : BPM_ZERO_AVG;
        end
        if ({1'b0, s} < fall_level)
            in_peak = 1'b0;
        r.peak_flag = in_peak;
        r.rate_bpm  = bpm_now;
        due_readings.push_back(r);
    endfunction

    function void compare_field(string field, logic [BPM_W-1:0] want, logic [BPM_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endfunction

    // Checks an accepted reading against the oldest one that is due.
    function void check_reading(logic pf, logic bs, logic [BPM_W-1:0] bpm);
        reading_t want;
        if (due_readings.size() == 0)
        begin
            $display("%0t: unexpected reading, expected none, actual flag %0d beat %0d bpm %0d",
                     $time, pf, bs, bpm);
            mismatches++;
            return;
        end
        want = due_readings.pop_front();
        compare_field("peak_flag", BPM_W'(want.peak_flag), BPM_W'(pf));
        compare_field("beat_seen", BPM_W'(want.beat_seen), BPM_W'(bs));
        compare_field("rate_bpm", want.rate_bpm, bpm);
    endfunction
endclass

module testbench;

    localparam int HALF_PERIOD = 5;
    // Cycles without any transaction on either channel before the run is
    // declared hung. A beat runs through the divider and a reading may be
    // held off by a run of receiver stall, so this leaves a wide margin.
    localparam int QUIET_LIMIT = 2000;
    // Planned beats after which the one-sample beat phases stop; this is
    // enough to fill the 500-entry window and then reuse its slots.
    localparam int BEAT_TARGET = 620;

    typedef enum int { STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS } stall_mode_t;

    logic                clk;
    logic                rst_n;
    logic                item_valid;
    logic                item_stall;
    logic [SAMPLE_W-1:0] sample;
    logic [SAMPLE_W-1:0] baseline;
    logic [TIME_W-1:0]   time_ms;
    logic                result_valid;
    logic                result_stall;
    logic                peak_flag;
    logic                beat_seen;
    logic [BPM_W-1:0]    rate_bpm;
    logic                cfg_we;
    cfg_index_t          cfg_index;
    logic [CFG_W-1:0]    cfg_data;

    pulse_tracker        book;

    // Stimulus bookkeeping: the running millisecond clock used for beats,
    // the register values in force, and the sender's burst state.
    logic [TIME_W-1:0]   now_ms;
    logic [CFG_W-1:0]    rise_cfg;
    logic [CFG_W-1:0]    fall_cfg;
    int unsigned         planned_beats;
    int unsigned         items_sent;
    int unsigned         burst_left;

    // Receiver stall pattern state.
    stall_mode_t         stall_mode = STALL_NONE;
    int                  mode_left  = 0;
    int                  run_left   = 0;

    heart_rate_peak_bpm_unit #(
        .WINDOW       (WINDOW_DEF)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .sample       (sample),
        .baseline     (baseline),
        .time_ms      (time_ms),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .peak_flag    (peak_flag),
        .beat_seen    (beat_seen),
        .rate_bpm     (rate_bpm),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial clk = 1'b0;
    always #(HALF_PERIOD) clk = ~clk;

    // Both channels are observed at the rising edge, where the unit samples
    // them too. An input transaction is logged with the predictor the moment
    // it is accepted, and an output transaction is checked against the
    // oldest reading still due. A sample's reading leaves only after the unit
    // has passed S_EVAL and S_OUT, so the two never meet at one edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall)
                book.take_sample(sample, baseline, time_ms);
            if (result_valid && !result_stall)
                book.check_reading(peak_flag, beat_seen, rate_bpm);
        end
    end

    // The receiver changes its stall at the falling edge. It moves between
    // stretches with no stall at all, light and heavy random stall, and
    // long solid runs of stall, each stretch lasting a random time.
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            mode_left  = $urandom_range(40, 300);
        end
        else
            mode_left--;
        case (stall_mode)
            STALL_NONE:  result_stall = 1'b0;
            STALL_LIGHT: result_stall = ($urandom_range(0, 3) == 0);
            STALL_HEAVY: result_stall = ($urandom_range(0, 3) != 0);
            default:
            begin
                if (run_left == 0)
                begin
                    result_stall = ~result_stall;
                    run_left = result_stall ? $urandom_range(5, 40) : $urandom_range(1, 8);
                end
                else
                    run_left--;
            end
        endcase
    end

    // Ends the run if neither channel completes a transaction for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("heart_rate_peak_bpm_unit regression: fail");
        $finish;
    end

    // Presents one sample and holds it until the unit takes it. The sender
    // works in bursts: while a burst lasts, the next sample follows at once
    // with valid left high; when it runs out, valid drops for a random gap.
    // Called and returning at a falling edge.
    task automatic send_item(input logic [SAMPLE_W-1:0] s, input logic [SAMPLE_W-1:0] b,
                             input logic [TIME_W-1:0] t);
        item_valid = 1'b1;
        sample     = s;
        baseline   = b;
        time_ms    = t;
        do
            @(posedge clk);
        while (item_stall !== 1'b0);
        items_sent++;
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            item_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(0, 12);
        end
    endtask

    // Holds the sender back until every due reading has come out, then lets
    // the unit settle. Registers are only written after this.
    task automatic drain();
        item_valid = 1'b0;
        while (book.due_readings.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Writes both margins, one per cycle, and tells the predictor.
    task automatic set_margins(input logic [CFG_W-1:0] peak_val,
                               input logic [CFG_W-1:0] rearm_val);
        cfg_we    = 1'b1;
        cfg_index = CFG_PEAK_MARGIN;
        cfg_data  = peak_val;
        @(negedge clk);
        cfg_index = CFG_REARM_MARGIN;
        cfg_data  = rearm_val;
        @(negedge clk);
        cfg_we = 1'b0;
        book.set_margin(CFG_PEAK_MARGIN, peak_val);
        book.set_margin(CFG_REARM_MARGIN, rearm_val);
        rise_cfg = peak_val;
        fall_cfg = rearm_val;
    endtask

    // Moves the beat clock on. Most steps are ordinary heart rates; a few
    // are near zero, which drives the average toward the top of the BPM
    // range, and a few are longer than a minute.
    task automatic advance_clock();
        case ($urandom_range(0, 19))
            0:       now_ms += $urandom_range(0, 3);
            1:       now_ms += $urandom_range(60001, 200000);
            default: now_ms += $urandom_range(300, 1500);
        endcase
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_level();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // A sample with no shape at all. Only a sample that could clear the peak
    // level carries the beat clock; any other may carry any timestamp,
    // since the unit ignores it.
    task automatic send_noise();
        logic [SAMPLE_W-1:0] s;
        logic [SAMPLE_W-1:0] b;
        logic [TIME_W-1:0]   t;
        s = pick_level();
        b = pick_level();
        if ({1'b0, s} > {1'b0, b} + {1'b0, rise_cfg})
        begin
            advance_clock();
            t = now_ms;
        end
        else
            t = $urandom;
        send_item(s, b, t);
    endtask

    // One beat shaped the way the detector expects it. When the re-arm
    // margin is at least two above the peak margin, most beats are one
    // sample that clears the peak level and is still below the re-arm level,
    // so the detector fires and drops in the same sample. Otherwise the beat
    // is a rising sample, a few in the hysteresis band, and a falling one.
    task automatic send_beat();
        int unsigned b;
        int unsigned top;
        if (rise_cfg == '1)
        begin
            // No sample can clear this peak level.
            send_noise();
            return;
        end
        advance_clock();
        planned_beats++;
        b = $urandom_range(0, 65534 - rise_cfg);
        if ((fall_cfg >= rise_cfg + 2) && ($urandom_range(0, 15) != 0))
        begin
            top = b + fall_cfg - 1;
            if (top > 65535)
                top = 65535;
            send_item(SAMPLE_W'($urandom_range(b + rise_cfg + 1, top)), SAMPLE_W'(b), now_ms);
            return;
        end
        send_item(SAMPLE_W'($urandom_range(b + rise_cfg + 1, 65535)), SAMPLE_W'(b), now_ms);
        repeat ($urandom_range(0, 3))
        begin
            b = $urandom_range(0, 65535 - fall_cfg);
            send_item(SAMPLE_W'($urandom_range(b + fall_cfg, 65535)), SAMPLE_W'(b),
                      now_ms + $urandom_range(1, 50));
        end
        b = $urandom_range((fall_cfg == 0) ? 1 : 0, 65535);
        top = b + fall_cfg - 1;
        if (top > 65535)
            top = 65535;
        send_item(SAMPLE_W'($urandom_range(0, top)), SAMPLE_W'(b),
                  now_ms + $urandom_range(10, 200));
    endtask

    // Sends about count samples, beat_pct percent of the picks being beats.
    task automatic run_items(input int unsigned count, input int unsigned beat_pct);
        int unsigned first;
        first = items_sent;
        while (items_sent - first < count)
        begin
            if ($urandom_range(1, 100) <= beat_pct)
                send_beat();
            else
                send_noise();
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0] pm;
        book          = new();
        rst_n         = 1'b0;
        item_valid    = 1'b0;
        sample        = '0;
        baseline      = '0;
        time_ms       = '0;
        result_stall  = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_PEAK_MARGIN;
        cfg_data      = '0;
        now_ms        = '0;
        rise_cfg      = PEAK_MARGIN_RST;
        fall_cfg      = REARM_MARGIN_RST;
        planned_beats = 0;
        items_sent    = 0;
        burst_left    = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed samples at the reset margins (peak 1000, re-arm 500).
        // All zero: no beat, and the detector stays disarmed.
        send_item(16'd0, 16'd0, 32'd0);
        // The first beat counts its interval from time zero; a zero average
        // gives the fixed rate of 60.
        send_item(16'hFFFF, 16'd0, 32'd0);
        // Still armed: no new beat whatever the timestamp says.
        send_item(16'hFFFF, 16'd0, 32'hFFFF_FFFF);
        send_item(16'd0, 16'hFFFF, 32'd0);
        // Interval of 1 ms: the average truncates to zero again.
        send_item(16'hFFFF, 16'd0, 32'd1);
        // The re-arm level of a top baseline lies above 16 bits; a wrapped
        // level would keep the detector armed here.
        send_item(16'd1000, 16'hFFFF, 32'd1);
        // Average of 1 ms gives the highest rate.
        send_item(16'hFFFF, 16'd0, 32'd3);
        // Just below the re-arm level, then exactly at the peak level.
        send_item(16'd1499, 16'd1000, 32'd3);
        send_item(16'd2000, 16'd1000, 32'd500);
        send_item(16'd2001, 16'd1000, 32'd1000);
        // Exactly at the re-arm level keeps the detector armed.
        send_item(16'd1500, 16'd1000, 32'd1010);
        send_item(16'd1499, 16'd1000, 32'd1020);
        // A peak level at the top of the sample range cannot be cleared,
        // one step lower it can.
        send_item(16'hFFFF, 16'd64535, 32'd1100);
        send_item(16'hFFFF, 16'd64534, 32'd1600);
        send_item(16'd0, 16'd0, 32'd1610);
        // An interval longer than a minute.
        send_item(16'hFFFF, 16'd0, 32'd71600);
        send_item(16'hAAAA, 16'h5555, 32'hAAAA_AAAA);
        send_item(16'h5555, 16'hAAAA, 32'h5555_5555);
        now_ms = 32'd71600;

        // Ordinary margins with the re-arm level at most the peak level. Half
        // way through, the sender waits until every reading is out.
        drain();
        pm = CFG_W'($urandom_range(500, 3000));
        set_margins(pm, CFG_W'($urandom_range(0, pm)));
        run_items(80, 75);
        drain();
        run_items(80, 75);

        // Both margins at zero.
        drain();
        set_margins('0, '0);
        run_items(50, 70);

        // Both margins at the top: nothing can ever be a beat.
        drain();
        set_margins('1, '1);
        run_items(20, 50);

        // Re-arm margin above the peak margin: beats that start and end in
        // one sample. This is where the window fills and its slots are
        // reused.
        do
        begin
            drain();
            pm = CFG_W'($urandom_range(0, 2000));
            set_margins(pm, pm + CFG_W'($urandom_range(2, 6000)));
            run_items(150, 90);
        end
        while (planned_beats < BEAT_TARGET);

        // Margins anywhere in their range, including the top re-arm margin
        // with a zero peak margin.
        drain();
        set_margins(CFG_W'($urandom), CFG_W'($urandom));
        run_items(50, 60);
        drain();
        set_margins('0, '1);
        run_items(20, 60);
        drain();
        set_margins(CFG_W'($urandom), CFG_W'($urandom));
        run_items(40, 60);

        // Back to the reset margins, with the beat clock moved just under
        // the top of its range so that beats cross the timer wrap.
        drain();
        set_margins(PEAK_MARGIN_RST, REARM_MARGIN_RST);
        now_ms = 32'hFFFF_FFFF - $urandom_range(2000, 20000);
        run_items(80, 80);

        // Wait for the last readings, then give a stray one time to appear.
        drain();
        repeat (100) @(negedge clk);
        if (book.mismatches == 0 && book.due_readings.size() == 0)
            $display("heart_rate_peak_bpm_unit regression: pass");
        else
            $display("heart_rate_peak_bpm_unit regression: fail");
        $finish;
    end

endmodule
